>>> sv/gbd_pkg.sv
// Package for the Golomb bit decoder: item types, status codes, reset
// constants and the helper functions that derive code widths from the divisor.
// No dependencies.
`default_nettype none

package gbd_pkg;

    localparam int unsigned VALUE_BITS_DEF   = 32;
    localparam int unsigned DIVISOR_BITS_DEF = 16;
    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned REM_BITS         = 17;
    localparam int unsigned BLEFT_BITS       = 5;
    localparam int unsigned BW_BITS          = 6;

    localparam logic [31:0] DIVISOR_RESET = 32'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic code_bit;
        logic stream_end;
    } bit_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } word_item_t;

    // Codeword start information handed from the divisor register to the decoder.
    typedef struct packed {
        logic                  restart;
        logic                  start_quot;
        logic                  start_extra;
        logic [BLEFT_BITS-1:0] bits_init;
    } cfg_ctrl_t;

    // b = ceil(log2 m), the bit length of m - 1. m is at least one.
    function automatic logic [BW_BITS-1:0] gbd_width_b(input logic [31:0] m);
        logic [31:0]        mm1;
        logic [BW_BITS-1:0] b;
        mm1 = m - 32'd1;
        b   = '0;
        for (int i = 0; i < 32; i++) begin
            if (mm1[i]) begin
                b = BW_BITS'(i + 1);
            end
        end
        return b;
    endfunction

    function automatic logic [31:0] gbd_offset_l(input logic [31:0] m);
        logic [32:0] pow;
        pow = 33'd1 << gbd_width_b(m);
        return 32'(pow - {1'b0, m});
    endfunction

    function automatic logic [BLEFT_BITS-1:0] gbd_bits_init(input logic [BW_BITS-1:0] b);
        return (b == '0) ? '0 : BLEFT_BITS'(b - BW_BITS'(1));
    endfunction

    localparam logic [BLEFT_BITS-1:0] RESET_BITS_LEFT = gbd_bits_init(gbd_width_b(DIVISOR_RESET));
    localparam logic [31:0]           RESET_OFFSET    = gbd_offset_l(DIVISOR_RESET);
    localparam logic                  RESET_QUOT      = (DIVISOR_RESET == 32'd1);
    localparam logic                  RESET_EXTRA     = (DIVISOR_RESET == 32'd2);

endpackage

`default_nettype wire

>>> sv/golomb_bit_decoder.sv
// Top level of the Golomb bit decoder: input register, divisor register and
// decoding core. Depends on gbd_pkg, gbd_divisor, gbd_in_stage and gbd_core.
//
//   channel   direction  handshake                 payload
//   bit       in         bit_valid / bit_ready     bit_item (code_bit, stream_end)
//   word      out        word_valid / word_ready   word_item (value, status)
//   divisor   in         divisor_we                divisor_wdata
//
// One code item can be accepted every cycle unless a held result or a restart
// stalls it; the item closing a codeword passes the input register, then the
// result register, before its result is valid.
// Reset sets the divisor to 8 and places the decoder at a codeword start.
// A held result stalls the input register, which then lowers bit_ready.
// A divisor write sets the restart flag of the divisor register, which restarts
// decoding; a held input item waits while that flag is set.
`default_nettype none

module golomb_bit_decoder #(
    parameter int unsigned VALUE_BITS   = gbd_pkg::VALUE_BITS_DEF,
    parameter int unsigned DIVISOR_BITS = gbd_pkg::DIVISOR_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    bit_valid,
    output logic                    bit_ready,
    input  gbd_pkg::bit_item_t      bit_item,
    output logic                    word_valid,
    input  logic                    word_ready,
    output gbd_pkg::word_item_t     word_item,
    input  logic                    divisor_we,
    input  logic [DIVISOR_BITS-1:0] divisor_wdata
);
    import gbd_pkg::*;

    logic [DIVISOR_BITS-1:0] m;
    logic [DIVISOR_BITS-1:0] l;
    cfg_ctrl_t               ctrl;
    logic                    take;
    logic                    stage_valid;
    bit_item_t               stage_item;

    gbd_divisor #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_divisor (
        .clk           (clk),
        .rst_n         (rst_n),
        .divisor_we    (divisor_we),
        .divisor_wdata (divisor_wdata),
        .m             (m),
        .l             (l),
        .ctrl          (ctrl)
    );

    gbd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .bit_valid   (bit_valid),
        .bit_ready   (bit_ready),
        .bit_item    (bit_item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    gbd_core #(
        .VALUE_BITS   (VALUE_BITS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .m           (m),
        .l           (l),
        .ctrl        (ctrl),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .take        (take),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .word_item   (word_item)
    );

endmodule

`default_nettype wire

>>> sv/gbd_divisor.sv
// Divisor register of the Golomb bit decoder with the derived offset l and
// the codeword start information. Depends on gbd_pkg.
`default_nettype none

module gbd_divisor #(
    parameter int unsigned DIVISOR_BITS = gbd_pkg::DIVISOR_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    divisor_we,
    input  logic [DIVISOR_BITS-1:0] divisor_wdata,
    output logic [DIVISOR_BITS-1:0] m,
    output logic [DIVISOR_BITS-1:0] l,
    output gbd_pkg::cfg_ctrl_t      ctrl
);
    import gbd_pkg::*;

    logic [DIVISOR_BITS-1:0] m_reg, m_next;
    logic [DIVISOR_BITS-1:0] l_reg, l_next;
    cfg_ctrl_t               ctrl_reg, ctrl_next;

    // A divisor of zero behaves as a divisor of one.
    always_comb begin
        m_next                = (divisor_wdata == '0) ? DIVISOR_BITS'(1) : divisor_wdata;
        l_next                = DIVISOR_BITS'(gbd_offset_l(32'(m_next)));
        ctrl_next.restart     = 1'b1;
        ctrl_next.start_quot  = (m_next == DIVISOR_BITS'(1));
        ctrl_next.start_extra = (m_next == DIVISOR_BITS'(2));
        ctrl_next.bits_init   = gbd_bits_init(gbd_width_b(32'(m_next)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg                <= DIVISOR_BITS'(DIVISOR_RESET);
            l_reg                <= DIVISOR_BITS'(RESET_OFFSET);
            ctrl_reg.restart     <= 1'b0;
            ctrl_reg.start_quot  <= RESET_QUOT;
            ctrl_reg.start_extra <= RESET_EXTRA;
            ctrl_reg.bits_init   <= RESET_BITS_LEFT;
        end
        else if (divisor_we)
        begin
            m_reg    <= m_next;
            l_reg    <= l_next;
            ctrl_reg <= ctrl_next;
        end
        else
        begin
            ctrl_reg.restart <= 1'b0;
        end
    end

    assign m    = m_reg;
    assign l    = l_reg;
    assign ctrl = ctrl_reg;

`ifndef NO_ASSERTIONS
    a_offset_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        l_reg < m_reg)
        else $error("offset l is not below the divisor");
`endif

endmodule

`default_nettype wire

>>> sv/gbd_in_stage.sv
// Input register of the Golomb bit decoder: holds one code item until the
// decoder takes it. Depends on gbd_pkg.
`default_nettype none

module gbd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               bit_valid,
    output logic               bit_ready,
    input  gbd_pkg::bit_item_t bit_item,
    input  logic               take,
    output logic               stage_valid,
    output gbd_pkg::bit_item_t stage_item
);
    import gbd_pkg::*;

    logic      valid_reg, valid_next;
    bit_item_t item_reg, item_next;

    always_comb begin
        bit_ready  = !valid_reg || take;
        valid_next = bit_valid || (valid_reg && !take);
        item_next  = (bit_valid && bit_ready) ? bit_item : item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            valid_reg <= bit_ready ? bit_valid : valid_next;
            item_reg  <= item_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

`ifndef NO_ASSERTIONS
    a_held_item_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !take) |=> (valid_reg && $stable(item_reg)))
        else $error("held input item lost or changed");
`endif

endmodule

`default_nettype wire

>>> sv/gbd_core.sv
// Decoding state and result register of the Golomb bit decoder: one code bit per cycle
// unless stalled, via remainder prefix, extra bit and unary quotient. Depends on gbd_pkg.
`default_nettype none

module gbd_core #(
    parameter int unsigned VALUE_BITS   = gbd_pkg::VALUE_BITS_DEF,
    parameter int unsigned DIVISOR_BITS = gbd_pkg::DIVISOR_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [DIVISOR_BITS-1:0] m,
    input  logic [DIVISOR_BITS-1:0] l,
    input  gbd_pkg::cfg_ctrl_t      ctrl,
    input  logic                    stage_valid,
    input  gbd_pkg::bit_item_t      stage_item,
    output logic                    take,
    output logic                    word_valid,
    input  logic                    word_ready,
    output gbd_pkg::word_item_t     word_item
);
    import gbd_pkg::*;

    localparam int unsigned AW = ((VALUE_BITS > DIVISOR_BITS) ? VALUE_BITS : DIVISOR_BITS) + 1;
    localparam int unsigned SW = ((VALUE_BITS > REM_BITS) ? VALUE_BITS : REM_BITS) + 1;
    localparam int unsigned CW = (REM_BITS > DIVISOR_BITS) ? REM_BITS : DIVISOR_BITS;
    localparam int unsigned XW = (REM_BITS + 1 > DIVISOR_BITS) ? REM_BITS + 1 : DIVISOR_BITS;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_EXTRA  = 2'd1,
        PH_QUOT   = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next, phase_init;
    logic [BLEFT_BITS-1:0]   bits_left_reg, bits_left_next, bits_dec;
    logic [REM_BITS-1:0]     rem_reg, rem_next, acc_shift;
    logic [VALUE_BITS-1:0]   qsum_reg, qsum_next;
    logic                    ovf_reg, ovf_next;
    logic                    word_valid_reg, word_valid_next;
    word_item_t              word_item_reg, word_item_next;
    logic                    at_start, emit, sat;
    logic [XW-1:0]           extra_x;
    logic [AW-1:0]           add_w;
    logic [SW-1:0]           sum_w;

    always_comb begin
        if (ctrl.start_quot)
            phase_init = PH_QUOT;
        else if (ctrl.start_extra)
            phase_init = PH_EXTRA;
        else
            phase_init = PH_PREFIX;
    end

    always_comb begin
        if (phase_reg != phase_init)
            at_start = 1'b0;
        else if (phase_reg == PH_PREFIX)
            at_start = (bits_left_reg == ctrl.bits_init);
        else if (phase_reg == PH_QUOT)
            at_start = (qsum_reg == '0) && !ovf_reg;
        else
            at_start = 1'b1;
    end

    // The held item waits while a divisor write restarts the decoder.
    assign take      = stage_valid && !ctrl.restart && (!word_valid_reg || word_ready);
    assign acc_shift = {rem_reg[REM_BITS-2:0], stage_item.code_bit};
    assign bits_dec  = (bits_left_reg != '0) ? bits_left_reg - BLEFT_BITS'(1) : '0;
    assign extra_x   = XW'({rem_reg, stage_item.code_bit});
    assign add_w     = AW'(qsum_reg) + AW'(m);
    assign sum_w     = SW'(qsum_reg) + SW'(rem_reg);

    // A remainder above the value maximum is passed through unsaturated.
    assign sat = ovf_reg || ((SW'(rem_reg) <= SW'(VALUE_MAX)) && (sum_w > SW'(VALUE_MAX)));

    always_comb begin
        phase_next     = phase_reg;
        bits_left_next = bits_left_reg;
        rem_next       = rem_reg;
        qsum_next      = qsum_reg;
        ovf_next       = ovf_reg;
        emit           = 1'b0;
        word_item_next = word_item_reg;

        if (ctrl.restart)
        begin
            phase_next     = phase_init;
            bits_left_next = ctrl.bits_init;
            rem_next       = '0;
            qsum_next      = '0;
            ovf_next       = 1'b0;
        end
        else if (take)
        begin
            if (stage_item.stream_end)
            begin
                if (!at_start)
                begin
                    emit                  = 1'b1;
                    word_item_next.value  = '0;
                    word_item_next.status = ST_TRUNC;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        rem_next       = acc_shift;
                        bits_left_next = bits_dec;
                        if (bits_dec == '0)
                            phase_next = (CW'(acc_shift) < CW'(l)) ? PH_QUOT : PH_EXTRA;
                    end
                    PH_EXTRA:
                    begin
                        rem_next   = (extra_x >= XW'(l)) ? REM_BITS'(extra_x - XW'(l)) : '0;
                        phase_next = PH_QUOT;
                    end
                    PH_QUOT:
                    begin
                        if (stage_item.code_bit)
                        begin
                            if (!ovf_reg)
                            begin
                                if (add_w > AW'(VALUE_MAX))
                                begin
                                    qsum_next = VALUE_MAX;
                                    ovf_next  = 1'b1;
                                end
                                else
                                begin
                                    qsum_next = VALUE_BITS'(add_w);
                                end
                            end
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (sat)
                            begin
                                word_item_next.value  = VALUE_W'(VALUE_MAX);
                                word_item_next.status = ST_SAT;
                            end
                            else
                            begin
                                word_item_next.value  = VALUE_W'(sum_w);
                                word_item_next.status = ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            // Every result closes a codeword, so decoding starts over.
            if (emit)
            begin
                phase_next     = phase_init;
                bits_left_next = ctrl.bits_init;
                rem_next       = '0;
                qsum_next      = '0;
                ovf_next       = 1'b0;
            end
        end

        if (emit)
            word_valid_next = 1'b1;
        else if (word_ready)
            word_valid_next = 1'b0;
        else
            word_valid_next = word_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= RESET_QUOT ? PH_QUOT : (RESET_EXTRA ? PH_EXTRA : PH_PREFIX);
            bits_left_reg  <= RESET_BITS_LEFT;
            rem_reg        <= '0;
            qsum_reg       <= '0;
            ovf_reg        <= 1'b0;
            word_valid_reg <= 1'b0;
            word_item_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bits_left_reg  <= bits_left_next;
            rem_reg        <= rem_next;
            qsum_reg       <= qsum_next;
            ovf_reg        <= ovf_next;
            word_valid_reg <= word_valid_next;
            word_item_reg  <= word_item_next;
        end
    end

    assign word_valid = word_valid_reg;
    assign word_item  = word_item_reg;

`ifndef NO_ASSERTIONS
    a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> at_start)
        else $error("decoder not at a codeword start after a result");

    a_trunc_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid_reg && (word_item_reg.status == ST_TRUNC)) |-> (word_item_reg.value == '0))
        else $error("truncation result with a nonzero value");

    a_overflow_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (qsum_reg == VALUE_MAX))
        else $error("overflow flag set while quotient sum is not saturated");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for golomb_bit_decoder: drives code bits, predicts decoded
// words with a bit-level decoder model of its own and checks every word item.
// Depends on gbd_pkg and the RTL of golomb_bit_decoder.

module testbench;

    import gbd_pkg::*;

    localparam int unsigned   QUIET_LIMIT  = 2000;
    localparam int unsigned   HOLD_CYCLES  = 300;
    localparam int unsigned   DRAIN_CYCLES = 6;
    localparam logic [63:0]   WORD_MAX     = 64'hFFFF_FFFF;

    typedef enum logic [1:0] {DEC_PREFIX, DEC_EXTRA, DEC_QUOT} dec_phase_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        bit_valid     = 1'b0;
    logic        bit_ready;
    bit_item_t   bit_item      = '0;
    logic        word_valid;
    logic        word_ready    = 1'b0;
    word_item_t  word_item;
    logic        divisor_we    = 1'b0;
    logic [15:0] divisor_wdata = '0;

    // Decoder state as the bench expects it.
    logic [15:0] pr_divisor;
    dec_phase_t  pr_phase;
    logic [4:0]  pr_bits_left;
    logic [16:0] pr_rem;
    logic [31:0] pr_qsum;
    logic        pr_ovf;

    bit_item_t   pending_bits[$];
    word_item_t  expected_words[$];
    int unsigned bits_queued    = 0;
    int unsigned bits_taken     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          pressure_on    = 1'b0;
    bit          pressure_used;

    golomb_bit_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .bit_valid     (bit_valid),
        .bit_ready     (bit_ready),
        .bit_item      (bit_item),
        .word_valid    (word_valid),
        .word_ready    (word_ready),
        .word_item     (word_item),
        .divisor_we    (divisor_we),
        .divisor_wdata (divisor_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] eff_divisor();
        return (pr_divisor == 0) ? 64'd1 : 64'(pr_divisor);
    endfunction

    function automatic int unsigned code_width(input logic [63:0] m);
        int unsigned w;
        w = 0;
        while (w < 40 && (64'd1 << w) < m)
            w++;
        return w;
    endfunction

    function automatic dec_phase_t entry_phase(input logic [63:0] m);
        if (m == 1)
            return DEC_QUOT;
        if (m == 2)
            return DEC_EXTRA;
        return DEC_PREFIX;
    endfunction

    task automatic restart_word();
        logic [63:0] m;
        int unsigned w;
        m = eff_divisor();
        w = code_width(m);
        pr_phase     = entry_phase(m);
        pr_bits_left = (w > 0) ? 5'(w - 1) : '0;
        pr_rem       = '0;
        pr_qsum      = '0;
        pr_ovf       = 1'b0;
    endtask

    function automatic bit word_at_start();
        logic [63:0] m;
        int unsigned w;
        m = eff_divisor();
        w = code_width(m);
        if (pr_phase != entry_phase(m))
            return 1'b0;
        if (pr_phase == DEC_PREFIX)
            return pr_bits_left == 5'(w - 1);
        if (pr_phase == DEC_QUOT)
            return pr_qsum == 0 && !pr_ovf;
        return 1'b1;
    endfunction

    task automatic decode_bit(input bit_item_t it);
        logic [63:0] m;
        logic [63:0] l;
        logic [17:0] x;
        word_item_t  w;
        m = eff_divisor();
        l = (64'd1 << code_width(m)) - m;
        if (it.stream_end)
        begin
            // An end marker only yields an item when a codeword was under way.
            if (!word_at_start())
            begin
                w.value  = '0;
                w.status = ST_TRUNC;
                expected_words.push_back(w);
                restart_word();
            end
            return;
        end
        case (pr_phase)
            DEC_PREFIX:
            begin
                pr_rem = {pr_rem[15:0], it.code_bit};
                if (pr_bits_left != 0)
                    pr_bits_left--;
                if (pr_bits_left == 0)
                    pr_phase = (pr_rem < l) ? DEC_QUOT : DEC_EXTRA;
            end
            DEC_EXTRA:
            begin
                x = {pr_rem, it.code_bit};
                pr_rem = (x >= l) ? 17'(x - l) : '0;
                pr_phase = DEC_QUOT;
            end
            default:
            begin
                if (it.code_bit)
                begin
                    if (!pr_ovf)
                    begin
                        if (64'(pr_qsum) + m > WORD_MAX)
                        begin
                            pr_qsum = '1;
                            pr_ovf  = 1'b1;
                        end
                        else
                            pr_qsum = 32'(64'(pr_qsum) + m);
                    end
                end
                else
                begin
                    if (pr_ovf || 64'(pr_qsum) + 64'(pr_rem) > WORD_MAX)
                    begin
                        w.value  = '1;
                        w.status = ST_SAT;
                    end
                    else
                    begin
                        w.value  = pr_qsum + 32'(pr_rem);
                        w.status = ST_OK;
                    end
                    expected_words.push_back(w);
                    restart_word();
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_word(input word_item_t got);
        word_item_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("word item with nothing pending: value %0d status %0d",
                                      got.value, got.status));
            return;
        end
        want = expected_words.pop_front();
        if (got.value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask

    task automatic queue_bit(input logic b, input logic e);
        bit_item_t it;
        it.code_bit   = b;
        it.stream_end = e;
        pending_bits.push_back(it);
        bits_queued++;
    endtask

    // Encodes quotient q and remainder r for the current divisor. A cut below the
    // codeword length sends only that many bits and then an end marker.
    task automatic queue_codeword(input int unsigned q, input int unsigned r, input int cut);
        logic [63:0] m;
        int unsigned w;
        int unsigned l;
        int unsigned code;
        int unsigned n;
        int          sent;
        bit          word_bits[$];
        m = eff_divisor();
        w = code_width(m);
        l = 32'((64'd1 << w) - m);
        if (m > 1)
        begin
            if (r < l)
            begin
                code = r;
                n    = w - 1;
            end
            else
            begin
                code = r + l;
                n    = w;
            end
            for (int i = int'(n) - 1; i >= 0; i--)
                word_bits.push_back(code[i]);
        end
        repeat (q) word_bits.push_back(1'b1);
        word_bits.push_back(1'b0);
        sent = (cut >= 0 && cut < word_bits.size()) ? cut : word_bits.size();
        for (int i = 0; i < sent; i++)
            queue_bit(word_bits[i], 1'b0);
        if (sent < word_bits.size())
            queue_bit($urandom_range(0, 1), 1'b1);
    endtask

    task automatic queue_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned q;
        int unsigned len;
        logic [63:0] m;
        m = eff_divisor();
        stop_at = bits_queued + n_items;
        while (bits_queued < stop_at)
        begin
            kind = $urandom_range(0, 99);
            q = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            if (kind < 70)
                queue_codeword(q, $urandom_range(0, 32'(m - 1)), -1);
            else if (kind < 85)
                queue_codeword(q, $urandom_range(0, 32'(m - 1)), $urandom_range(0, 20));
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) queue_bit($urandom_range(0, 1), $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 3) != 0)
                    queue_bit($urandom_range(0, 1), 1'b1);
            end
        end
    endtask

    // Items that end no codeword may still sit in the pipeline, hence the drain.
    task automatic wait_decoder_idle();
        while (bits_taken != bits_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_divisor(input logic [15:0] v);
        @(posedge clk);
        divisor_we    <= 1'b1;
        divisor_wdata <= v;
        @(posedge clk);
        divisor_we <= 1'b0;
        pr_divisor = v;
        restart_word();
        repeat (2) @(posedge clk);
    endtask

    // Sender: one item per handshake, with a drawn gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_valid <= 1'b0;
            bit_item  <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (bit_valid && bit_ready)
            begin
                decode_bit(bit_item);
                bits_taken++;
            end
            if (!bit_valid || bit_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    bit_valid <= 1'b0;
                end
                else if (pending_bits.size() != 0)
                begin
                    bit_item  <= pending_bits.pop_front();
                    bit_valid <= 1'b1;
                    send_gap  <= sender_idles ? $urandom_range(0, 4) : 0;
                end
                else
                    bit_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each word item, stalls at random and once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned d;
        if (!rst_n)
        begin
            word_ready    <= 1'b0;
            recv_gap      <= 0;
            hold_left     <= 0;
            pressure_used <= 1'b0;
        end
        else
        begin
            if (word_valid && word_ready)
                check_word(word_item);
            if (hold_left != 0)
            begin
                hold_left  <= hold_left - 1;
                word_ready <= 1'b0;
            end
            else if (pressure_on && !pressure_used)
            begin
                hold_left     <= HOLD_CYCLES;
                pressure_used <= 1'b1;
                word_ready    <= 1'b0;
            end
            else if (word_valid && word_ready)
            begin
                d = receiver_idles ? $urandom_range(0, 4) : 0;
                recv_gap   <= d;
                word_ready <= (d == 0);
            end
            else if (recv_gap != 0)
            begin
                recv_gap   <= recv_gap - 1;
                word_ready <= (recv_gap == 1);
            end
            else
                word_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (bit_valid && bit_ready) || (word_valid && word_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] divisor_plan[$];
        pr_divisor = 16'd8;
        restart_word();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset divisor, then the degenerate and short-prefix divisors.
        queue_codeword(0, 0, -1);
        queue_codeword(2, 7, -1);
        queue_bit(1'b1, 1'b1);
        queue_codeword(1, 3, 1);
        wait_decoder_idle();
        set_divisor(16'd1);
        queue_codeword(0, 0, -1);
        queue_codeword(2, 0, -1);
        queue_codeword(3, 0, 1);
        wait_decoder_idle();
        set_divisor(16'd0);
        queue_codeword(1, 0, -1);
        wait_decoder_idle();
        set_divisor(16'd2);
        queue_codeword(1, 1, -1);
        wait_decoder_idle();
        set_divisor(16'd5);
        queue_codeword(0, 4, 2);
        queue_codeword(0, 4, -1);
        wait_decoder_idle();

        divisor_plan = '{16'd8, 16'd1, 16'd2, 16'd3, 16'd0, 16'd7, 16'd100, 16'hFFFF,
                         16'h8000, 16'd1000, 16'd4097, 16'hFFFE};
        divisor_plan.push_back(16'($urandom));
        divisor_plan.push_back(16'($urandom_range(3, 300)));
        foreach (divisor_plan[i])
        begin
            set_divisor(divisor_plan[i]);
            sender_idles   = (i != 0) && ($urandom_range(0, 3) != 0);
            receiver_idles = (i != 0) && ($urandom_range(0, 3) != 0);
            if (eff_divisor() > 2)
            begin
                queue_codeword(0, 0, -1);
                queue_codeword(1, 32'(eff_divisor() - 1), -1);
            end
            queue_traffic(20);
            wait_decoder_idle();
        end

        // Long receiver stall while short codewords keep coming.
        set_divisor(16'd3);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        pressure_on    = 1'b1;
        repeat (25) queue_codeword($urandom_range(0, 1), $urandom_range(0, 2), -1);
        wait_decoder_idle();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
